// ----- rtl/nbody_total_energy_unit_macros.svh -----
// assertion macros shared by the energy unit modules
// depends on nothing; included by files that carry assertions
`ifndef NBODY_TOTAL_ENERGY_UNIT_MACROS_SVH
`define NBODY_TOTAL_ENERGY_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define NTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nte check failed");

// next-cycle implication checked outside reset
`define NTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nte check failed");

`endif

// ----- rtl/nte_pkg.sv -----
// shared types and constants for the n-body energy unit
// no dependencies
`timescale 1ns / 1ps
package nte_pkg;
  localparam int unsigned NumBodies = 4;
  localparam int unsigned NumRegs = 4;
  localparam logic [1:0] RegMassZero  = 2'd0;
  localparam logic [1:0] RegMassOne   = 2'd1;
  localparam logic [1:0] RegMassTwo   = 2'd2;
  localparam logic [1:0] RegMassThree = 2'd3;
  localparam logic [63:0] I64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64Min = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } body_t;

  typedef struct packed {
    logic [63:0] energy;
    logic        overflow;
  } result_t;

  // front to back queue entry: a classified body with its slot
  typedef struct packed {
    logic [1:0]  slot;
    logic        last;
    logic [31:0] mass;
    body_t       body;
  } job_t;
endpackage

// ----- rtl/nte_stream_if.sv -----
// valid/ready channel carrying one payload beat
// depends on nothing
`timescale 1ns / 1ps
interface nte_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nte_front.sv -----
// front end: tags each body with its slot and the mass at arrival
// depends on nte_pkg
`timescale 1ns / 1ps
module nte_front import nte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  body_t       in_body,
  input  logic [31:0] mass [NumBodies],
  output logic        q_valid,
  input  logic        q_ready,
  output job_t        q_job
);
  logic [1:0] slot_r, slot_nxt;
  logic       fire;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign fire     = in_valid && q_ready;
  assign q_job.slot = slot_r;
  assign q_job.last = (slot_r == 2'd3);
  assign q_job.mass = mass[slot_r];
  assign q_job.body = in_body;
  assign slot_nxt = fire ? slot_r + 2'd1 : slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r <= '0;
    else slot_r <= slot_nxt;
  end
endmodule

// ----- rtl/nte_fifo.sv -----
// two-entry queue between front and back ends
// depends on nte_pkg
`timescale 1ns / 1ps
module nte_fifo import nte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  `include "nbody_total_energy_unit_macros.svh"
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  `NTE_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `NTE_ASSERT_NXT(a_full_hold, (cnt_r == 2'd2) && !rd, cnt_r == 2'd2)
  `NTE_ASSERT_IMP(a_ptr_cnt, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r)
endmodule

// ----- rtl/nte_back.sv -----
// back end: kinetic accumulate, pair distances by bit-serial sqrt,
// potential by restoring division; depends on nte_pkg
`timescale 1ns / 1ps
module nte_back import nte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  job_t        q_job,
  input  logic [31:0] mass [NumBodies],
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);
  `include "nbody_total_energy_unit_macros.svh"
  typedef enum logic [3:0] {
    S_IDLE, S_KIN1, S_KIN2, S_KIN3, S_PAIR, S_D2A, S_D2B, S_SQ,
    S_MM, S_DIV, S_ACC, S_FIN, S_OUT
  } state_t;

  state_t       state_r;
  logic [31:0]  px_r [NumBodies];
  logic [31:0]  py_r [NumBodies];
  logic [63:0]  ksum_r;
  logic         kflag_r;
  logic [63:0]  pot_r;
  logic         coin_r;
  logic [31:0]  kmass_r;
  logic [31:0]  vx_r, vy_r;
  logic [63:0]  v2_r;
  logic [95:0]  kprod_r;
  logic [2:0]   pair_r;
  logic [1:0]   pi_r, pj_r;
  logic [32:0]  dx_r, dy_r;
  logic [65:0]  num_r;
  logic [33:0]  root_r;
  logic [5:0]   step_r;
  logic [63:0]  mm_r;
  logic [79:0]  dn_r;
  logic [35:0]  rem_r;
  logic [79:0]  quo_r;
  logic [6:0]   dstep_r;
  logic         last_r;
  result_t      res_w;
  logic [63:0]  pt;
  logic [64:0]  psum;
  logic [64:0]  ksum_w;
  logic [95:0]  kterm_w;
  logic [35:0]  rem_sh;
  logic [67:0]  num_x;

  assign q_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_res  = res_w;

  function automatic logic [1:0] pair_i(input logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd2: pair_i = 2'd0;
      3'd3, 3'd4:       pair_i = 2'd1;
      default:          pair_i = 2'd2;
    endcase
  endfunction
  function automatic logic [1:0] pair_j(input logic [2:0] p);
    case (p)
      3'd0:       pair_j = 2'd1;
      3'd1, 3'd3: pair_j = 2'd2;
      default:    pair_j = 2'd3;
    endcase
  endfunction

  assign kterm_w = kprod_r >> 17;
  assign ksum_w  = {1'b0, ksum_r} + {1'b0, ((|kterm_w[95:63]) ? I64Max : kterm_w[63:0])};
  assign rem_sh  = {rem_r[34:0], dn_r[79]};
  assign num_x   = {2'b0, num_r};
  assign pt      = (|quo_r[79:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : quo_r[63:0];
  assign psum    = {1'b0, pot_r} + {1'b0, pt};

  // sqrt working term: bit position 2*step
  logic [67:0] bitv;
  assign bitv = 68'd1 << {step_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ksum_r  <= '0;
      kflag_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          px_r[q_job.slot] <= q_job.body.pos_x;
          py_r[q_job.slot] <= q_job.body.pos_y;
          kmass_r <= q_job.mass;
          vx_r <= q_job.body.vel_x[31] ? 32'(-q_job.body.vel_x) : q_job.body.vel_x;
          vy_r <= q_job.body.vel_y[31] ? 32'(-q_job.body.vel_y) : q_job.body.vel_y;
          last_r <= q_job.last;
          state_r <= S_KIN1;
        end
        S_KIN1: begin
          v2_r <= 64'(vx_r) * 64'(vx_r);
          state_r <= S_KIN2;
        end
        S_KIN2: begin
          v2_r <= v2_r + 64'(vy_r) * 64'(vy_r);
          state_r <= S_KIN3;
        end
        S_KIN3: begin
          // mass times v2 as two 32x32 halves
          kprod_r <= {64'(kmass_r) * 64'(v2_r[63:32]), 32'b0}
                   + 96'(64'(kmass_r) * 64'(v2_r[31:0]));
          state_r <= S_FIN;
        end
        S_FIN: begin
          kflag_r <= kflag_r | (|kterm_w[95:63]) | (ksum_w > {1'b0, I64Max});
          if (ksum_w > {1'b0, I64Max}) ksum_r <= I64Max;
          else ksum_r <= ksum_w[63:0];
          if (last_r) begin
            pair_r <= '0; pot_r <= '0; coin_r <= 1'b0;
            state_r <= S_PAIR;
          end else state_r <= S_IDLE;
        end
        S_PAIR: begin
          pi_r <= pair_i(pair_r);
          pj_r <= pair_j(pair_r);
          state_r <= S_D2A;
        end
        S_D2A: begin
          dx_r <= {px_r[pi_r][31], px_r[pi_r]} - {px_r[pj_r][31], px_r[pj_r]};
          dy_r <= {py_r[pi_r][31], py_r[pi_r]} - {py_r[pj_r][31], py_r[pj_r]};
          state_r <= S_D2B;
        end
        S_D2B: begin
          num_r <= 66'(64'(dx_r[32] ? 33'(-dx_r) : dx_r) * 64'(dx_r[32] ? 33'(-dx_r) : dx_r))
                 + 66'(64'(dy_r[32] ? 33'(-dy_r) : dy_r) * 64'(dy_r[32] ? 33'(-dy_r) : dy_r));
          root_r <= '0;
          step_r <= 6'd33;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // one result bit per cycle, restoring square root
          if (num_x >= ({2'b0, 32'b0, root_r} << (step_r + 6'd1)) + bitv) begin
            num_r <= 66'(num_x - (({2'b0, 32'b0, root_r} << (step_r + 6'd1)) + bitv));
            root_r <= root_r | (34'd1 << step_r);
          end
          if (step_r == 6'd0) state_r <= S_MM;
          else step_r <= step_r - 6'd1;
        end
        S_MM: begin
          mm_r <= 64'(mass[pi_r]) * 64'(mass[pj_r]);
          state_r <= S_DIV;
          rem_r <= '0;
          quo_r <= '0;
          dstep_r <= 7'd80;
        end
        S_DIV: begin
          if (dstep_r == 7'd80) begin
            dn_r <= {mm_r, 16'b0};
            dstep_r <= dstep_r - 7'd1;
            if (root_r == '0) begin
              coin_r <= 1'b1;
              state_r <= S_ACC;
            end
          end else begin
            dn_r <= dn_r << 1;
            if (rem_sh >= 36'(root_r)) begin
              rem_r <= rem_sh - 36'(root_r);
              quo_r <= {quo_r[78:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[78:0], 1'b0};
            end
            if (dstep_r == 7'd0) state_r <= S_ACC;
            else dstep_r <= dstep_r - 7'd1;
          end
        end
        S_ACC: begin
          if (root_r != '0) pot_r <= psum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : psum[63:0];
          if (pair_r == 3'd5) begin
            state_r <= S_OUT;
          end else begin
            pair_r <= pair_r + 3'd1;
            state_r <= S_PAIR;
          end
        end
        S_OUT: if (out_ready) begin
          ksum_r <= '0; kflag_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result formed from final sums
  logic [63:0] diff;
  assign diff = pot_r - ksum_r;
  always_comb begin
    res_w.overflow = kflag_r;
    if (coin_r) begin
      res_w.energy = I64Min; res_w.overflow = 1'b1;
    end else if (pot_r <= ksum_r) res_w.energy = ksum_r - pot_r;
    else if (diff > I64Min) begin
      res_w.energy = I64Min; res_w.overflow = 1'b1;
    end else res_w.energy = 64'(0) - diff;
  end

  `NTE_ASSERT_IMP(a_ksum_cap, 1'b1, ksum_r <= I64Max)
  `NTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `NTE_ASSERT_IMP(a_busy_noaccept, state_r != S_IDLE, !q_ready)
endmodule

// ----- rtl/nbody_total_energy_unit.sv -----
// top level of the four-body total energy unit
// depends on nte_pkg, nte_stream_if, nte_front, nte_fifo, nte_back
`timescale 1ns / 1ps
// Takes four bodies per group (body 0 first) as Q16.16 position and velocity
// beats, and after the fourth beat returns one beat with total energy
// (kinetic minus potential, signed Q32.32, saturated) and an overflow flag.
// Each body passes the kinetic states KIN1, KIN2, KIN3 and FIN in the back
// end; the fourth body adds six pair passes (a 34-step square root and an
// 80-step restoring division, one bit per cycle). Masses are to be written
// on the cfg port only while idle; the block itself does not enforce this.
module nbody_total_energy_unit import nte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nte_stream_if.sink   in_ch,
  nte_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] mass_r [NumBodies];
  logic        q_valid, q_ready, b_valid, b_ready;
  job_t        q_job, b_job;
  result_t     res;

  // mass registers, reset to 1.0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumBodies; i++) mass_r[i] <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMassZero:  mass_r[0] <= cfg_data;
        RegMassOne:   mass_r[1] <= cfg_data;
        RegMassTwo:   mass_r[2] <= cfg_data;
        RegMassThree: mass_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  nte_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_body(in_ch.data), .mass(mass_r),
    .q_valid, .q_ready, .q_job
  );
  nte_fifo u_fifo (
    .clk, .rst_n, .wr_valid(q_valid), .wr_ready(q_ready), .wr_data(q_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );
  nte_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_job(b_job),
    .mass(mass_r), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res(res)
  );
  assign out_ch.data = res;
endmodule

// ----- bench/tb_nbody_total_energy_unit.sv -----
// self-checking bench for the four-body total energy unit
// depends on nte_pkg, nte_stream_if and nbody_total_energy_unit from the rtl
`timescale 1ns / 1ps
module tb_nbody_total_energy_unit;
  import nte_pkg::*;

  // a group runs many serial steps inside the block, so keep generous margins
  localparam int unsigned SettleCycles = 900;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomGroups = 370;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  nte_stream_if #(.payload_t(body_t)) in_ch ();
  nte_stream_if #(.payload_t(result_t)) out_ch ();

  nbody_total_energy_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block: masses, stored positions, running kinetic sum
  logic [31:0] mass_shadow [NumBodies];
  logic signed [31:0] shadow_x [NumBodies];
  logic signed [31:0] shadow_y [NumBodies];
  logic [63:0] kinetic_acc;
  logic [1:0] loaded;
  bit kinetic_sat;

  result_t energy_q[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned flagged_seen = 0;
  int unsigned idle_cycles;
  bit quiet;
  bit timed_out;

  // floor square root of a sum of two squares, up to 66 bits
  function automatic logic [33:0] floor_sqrt(logic [65:0] val);
    logic [33:0] root;
    logic [67:0] sq;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      root[i] = 1'b1;
      sq = {34'd0, root} * {34'd0, root};
      if (sq > {2'b00, val}) root[i] = 1'b0;
    end
    return root;
  endfunction

  // one body in; returns 1 with the energy beat when the group closes
  function automatic bit energy_predict(body_t b, output result_t res);
    logic [32:0] vx, vy, dx, dy;
    logic [63:0] v2;
    logic [95:0] prod;
    logic [64:0] ksum;
    logic [65:0] d2;
    logic [33:0] dist_q16;
    logic [79:0] quot;
    logic [64:0] pot;
    logic [63:0] term, diff;
    bit coincide;
    vx = b.vel_x < 0 ? -{b.vel_x[31], b.vel_x} : {1'b0, b.vel_x};
    vy = b.vel_y < 0 ? -{b.vel_y[31], b.vel_y} : {1'b0, b.vel_y};
    v2 = vx * vx + vy * vy;
    prod = {64'd0, mass_shadow[loaded]} * {32'd0, v2};
    prod = prod >> 17;
    if (prod > {32'd0, I64Max}) begin
      term = I64Max;
      kinetic_sat = 1;
    end else begin
      term = prod[63:0];
    end
    ksum = {1'b0, kinetic_acc} + {1'b0, term};
    if (ksum > {1'b0, I64Max}) begin
      kinetic_acc = I64Max;
      kinetic_sat = 1;
    end else begin
      kinetic_acc = ksum[63:0];
    end
    shadow_x[loaded] = b.pos_x;
    shadow_y[loaded] = b.pos_y;
    if (loaded != 2'd3) begin
      loaded = loaded + 2'd1;
      return 0;
    end
    pot = '0;
    coincide = 0;
    for (int i = 0; i < NumBodies; i++) begin
      for (int j = i + 1; j < NumBodies; j++) begin
        dx = {shadow_x[i][31], shadow_x[i]} - {shadow_x[j][31], shadow_x[j]};
        dy = {shadow_y[i][31], shadow_y[i]} - {shadow_y[j][31], shadow_y[j]};
        if (dx[32]) dx = -dx;
        if (dy[32]) dy = -dy;
        d2 = {33'd0, dx} * {33'd0, dx} + {33'd0, dy} * {33'd0, dy};
        dist_q16 = floor_sqrt(d2);
        if (dist_q16 == 0) begin
          coincide = 1;
        end else begin
          quot = {{16'd0, {32'd0, mass_shadow[i]} * {32'd0, mass_shadow[j]}} << 16}
                 / {46'd0, dist_q16};
          term = (quot[79:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0];
          pot = pot + {1'b0, term};
          if (pot[64]) pot = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
      end
    end
    res.overflow = kinetic_sat;
    if (coincide) begin
      res.energy = I64Min;
      res.overflow = 1;
    end else if (pot[63:0] <= kinetic_acc) begin
      res.energy = kinetic_acc - pot[63:0];
    end else begin
      diff = pot[63:0] - kinetic_acc;
      if (diff > I64Min) begin
        res.energy = I64Min;
        res.overflow = 1;
      end else begin
        res.energy = -diff;
      end
    end
    loaded = '0;
    kinetic_acc = '0;
    kinetic_sat = 0;
    return 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts, compare each beat with the oldest expectation
  int unsigned stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (energy_q.size() == 0) begin
          $error("unexpected energy beat: energy %h overflow %b",
                 out_ch.data.energy, out_ch.data.overflow);
          errors++;
        end else begin
          if (out_ch.data.energy !== energy_q[0].energy) begin
            $error("energy: expected %h actual %h", energy_q[0].energy, out_ch.data.energy);
            errors++;
          end
          if (out_ch.data.overflow !== energy_q[0].overflow) begin
            $error("overflow: expected %b actual %b",
                   energy_q[0].overflow, out_ch.data.overflow);
            errors++;
          end
          if (energy_q[0].overflow) flagged_seen <= flagged_seen + 1;
          void'(energy_q.pop_front());
        end
      end
      // random stall bursts, none started once the run goes quiet
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      // watchdog: cycles without any beat moving on either side
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d energy beats outstanding", energy_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // drive one body beat, with an optional gap ahead of it
  task automatic send_body(body_t b, bit has_fixed, result_t fixed);
    result_t res;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (energy_predict(b, res)) energy_q.push_back(has_fixed ? fixed : res);
  endtask

  task automatic write_masses(logic [31:0] m0, logic [31:0] m1,
                              logic [31:0] m2, logic [31:0] m3);
    logic [31:0] vals [NumRegs];
    logic [1:0] idx [NumRegs];
    vals = '{m0, m1, m2, m3};
    idx = '{RegMassZero, RegMassOne, RegMassTwo, RegMassThree};
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      mass_shadow[idx[i]] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // block is idle once every expected beat is back and the tail has passed
  task automatic drain(int unsigned tail);
    in_ch.valid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h0001_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // coordinates mostly near the origin, sometimes anywhere in the plane
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // directed rows: the fourth row of a group may carry a hand-written result
  typedef struct {
    body_t b;
    bit has_fixed;
    result_t fixed;
  } stim_row_t;

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] PMax = 32'h7FFF_FFFF;
  localparam logic [31:0] PMin = 32'h8000_0000;

  stim_row_t directed [20];
  result_t no_result;

  initial begin
    body_t b;
    int unsigned kind;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = RegMassZero;
    cfg_data = '0;
    rst_n = 1'b0;
    quiet = 0;
    timed_out = 0;
    no_result = '0;
    for (int i = 0; i < NumBodies; i++) begin
      mass_shadow[i] = One;
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    kinetic_acc = '0;
    loaded = '0;
    kinetic_sat = 0;

    // all bodies at rest on one point: coincident, saturated low
    directed[0] = '{'{0, 0, 0, 0}, 0, no_result};
    directed[1] = '{'{0, 0, 0, 0}, 0, no_result};
    directed[2] = '{'{0, 0, 0, 0}, 0, no_result};
    directed[3] = '{'{0, 0, 0, 0}, 1, '{I64Min, 1'b1}};
    // corners of the plane with extreme velocities
    directed[4] = '{'{PMax, PMax, PMax, PMin}, 0, no_result};
    directed[5] = '{'{PMin, PMin, PMin, PMax}, 0, no_result};
    directed[6] = '{'{PMax, PMin, PMin, PMin}, 0, no_result};
    directed[7] = '{'{PMin, PMax, PMax, PMax}, 0, no_result};
    // unit square at rest: potential only, negative energy
    directed[8] = '{'{0, 0, 0, 0}, 0, no_result};
    directed[9] = '{'{One, 0, 0, 0}, 0, no_result};
    directed[10] = '{'{0, One, 0, 0}, 0, no_result};
    directed[11] = '{'{One, One, 0, 0}, 0, no_result};
    // bodies one and three coincide while moving fast
    directed[12] = '{'{0, 0, PMin, PMin}, 0, no_result};
    directed[13] = '{'{One, One, PMax, 1}, 0, no_result};
    directed[14] = '{'{-One, One, -1, PMax}, 0, no_result};
    directed[15] = '{'{One, One, 1, -1}, 1, '{I64Min, 1'b1}};
    // smallest nonzero spacing with tiny velocities
    directed[16] = '{'{0, 0, 1, 0}, 0, no_result};
    directed[17] = '{'{1, 0, 0, 1}, 0, no_result};
    directed[18] = '{'{0, 1, -1, 0}, 0, no_result};
    directed[19] = '{'{1, 1, 0, -1}, 0, no_result};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset masses of 1.0 first
    foreach (directed[i]) send_body(directed[i].b, directed[i].has_fixed, directed[i].fixed);
    drain(20);

    // largest masses: kinetic and potential both saturate
    write_masses(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 4; i < 12; i++) send_body(directed[i].b, 0, no_result);
    for (int i = 16; i < 20; i++) send_body(directed[i].b, 0, no_result);
    drain(20);

    // massless bodies: energy is zero unless bodies coincide
    write_masses(0, 0, 0, 0);
    for (int i = 4; i < 12; i++) send_body(directed[i].b, 0, no_result);
    drain(20);

    // random phases with fresh masses; the last phase runs without idling
    for (int g = 0; g < RandomGroups; g++) begin
      if (g % 40 == 0) begin
        drain(20);
        if (g >= RandomGroups - 40) quiet = 1;
        write_masses(pick_mass(), pick_mass(), pick_mass(), pick_mass());
      end
      kind = $urandom_range(0, 15);
      for (int k = 0; k < NumBodies; k++) begin
        b.pos_x = pick_coord();
        b.pos_y = pick_coord();
        b.vel_x = pick_vel();
        b.vel_y = pick_vel();
        // now and then make the closing body land on an earlier one
        if (kind == 0 && k == 3) begin
          kind = $urandom_range(0, 2);
          b.pos_x = shadow_x[kind];
          b.pos_y = shadow_y[kind];
        end
        send_body(b, 0, no_result);
      end
    end

    in_ch.valid <= 1'b0;
    begin
      int unsigned waited;
      waited = 0;
      while (energy_q.size() != 0 && waited < 50 * SettleCycles) begin
        @(posedge clk);
        waited++;
      end
      if (energy_q.size() != 0) timed_out = 1;
    end
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d energy groups over %0d mass settings, %0d of them flagged",
             results_seen, RandomGroups / 40 + 4, flagged_seen);
    if (errors == 0 && !timed_out && energy_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
